FILE: src/atx_hd_pkg.sv
package atx_hd_pkg;

  // Width of every position field on the result channel.
  localparam int OUT_POS_W = 16;
  localparam int LEVEL_W   = 3;

  // Default width of the internal position counter.
  localparam int POS_BITS_DEF = 16;

  // Character codes the scanner looks for.
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Deepest heading level.
  localparam logic [LEVEL_W-1:0] MAX_LEVEL = 3'd6;

  // Line scanner phase, one-hot.
  typedef enum logic [3:0] {
    PH_LINE = 4'b0001,
    PH_HASH = 4'b0010,
    PH_TEXT = 4'b0100,
    PH_SKIP = 4'b1000
  } phase_t;

  // One heading report.
  typedef struct packed {
    logic [LEVEL_W-1:0]   level;
    logic [OUT_POS_W-1:0] heading_start;
    logic [OUT_POS_W-1:0] text_begin;
    logic [OUT_POS_W-1:0] text_stop;
    logic [OUT_POS_W-1:0] heading_stop;
  } heading_t;

endpackage

FILE: src/atx_heading_detector_unit.sv
// ATX heading detector.
// The input channel (in_valid, in_stall, in_byte, in_last) takes a document
// one byte per request; in_last marks the final byte of a document. The
// result channel (out_valid, out_stall and the field ports) carries one
// request for each heading found, in document order.
// A byte is accepted in every cycle that in_valid is high and in_stall low,
// so the sustained rate is one byte per cycle. The scanner state is a single
// register stage updated by compare logic on the accepted byte.
// A report for the byte that completes the heading (its newline or the final
// byte of the document) is registered in the output or skid register.
// When the receiver stalls, the pending report holds on the output register
// and one more report can wait in a skid register; only when that register
// is occupied does in_stall rise, and it falls as soon as the output drains.
// Synchronous reset (rst_n low) empties both registers and returns the
// scanner to the start of a document at position zero.
module atx_heading_detector_unit #(
  parameter int POS_BITS = atx_hd_pkg::POS_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            in_byte,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [atx_hd_pkg::LEVEL_W-1:0]        out_level,
  output logic [atx_hd_pkg::OUT_POS_W-1:0]      out_heading_start,
  output logic [atx_hd_pkg::OUT_POS_W-1:0]      out_text_begin,
  output logic [atx_hd_pkg::OUT_POS_W-1:0]      out_text_stop,
  output logic [atx_hd_pkg::OUT_POS_W-1:0]      out_heading_stop
);
  import atx_hd_pkg::*;

  logic     accept;
  logic     emit;
  heading_t result;
  logic     out_free;

  logic     out_v_r;
  heading_t out_r;
  logic     skid_v_r;
  heading_t skid_r;

  assign in_stall = skid_v_r;
  assign accept   = in_valid && !skid_v_r;
  assign out_free = !out_v_r || !out_stall;

  atx_hd_scan #(
    .POS_BITS(POS_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .emit    (emit),
    .result  (result)
  );

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= accept && emit;
      end
    end else if (accept && emit) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_v_r ? skid_r : result;
    end else if (accept && emit) begin
      skid_r <= result;
    end
  end

  assign out_valid         = out_v_r;
  assign out_level         = out_r.level;
  assign out_heading_start = out_r.heading_start;
  assign out_text_begin    = out_r.text_begin;
  assign out_text_stop     = out_r.text_stop;
  assign out_heading_stop  = out_r.heading_stop;

endmodule

FILE: src/atx_hd_scan.sv
module atx_hd_scan #(
  parameter int POS_BITS = atx_hd_pkg::POS_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output logic                 emit,
  output atx_hd_pkg::heading_t result
);
  import atx_hd_pkg::*;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  phase_t              phase_r, phase_nxt;
  logic [LEVEL_W-1:0]  hash_r, hash_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] start_r, start_nxt;
  logic [POS_BITS-1:0] text_r, text_nxt;
  logic [POS_BITS-1:0] content_r, content_nxt;

  logic [POS_BITS-1:0] pos_inc;
  logic [POS_BITS-1:0] tb, ts, hs;
  logic                line_end;

  // Saturating position of the following byte.
  assign pos_inc = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;

  // Next-state and report logic for one byte.
  always_comb begin
    phase_nxt   = phase_r;
    hash_nxt    = hash_r;
    start_nxt   = start_r;
    text_nxt    = text_r;
    content_nxt = content_r;
    pos_nxt     = pos_inc;
    emit        = 1'b0;
    tb          = pos_inc;
    ts          = pos_inc;
    hs          = pos_inc;
    line_end    = 1'b0;

    unique case (phase_r)
      PH_LINE: begin
        if (in_byte == CH_HASH) begin
          hash_nxt  = 3'd1;
          start_nxt = pos_r;
          if (in_last) begin
            emit = 1'b1;
          end else begin
            phase_nxt = PH_HASH;
          end
        end else if (in_byte == CH_NL) begin
          line_end = 1'b1;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_HASH: begin
        if (in_byte == CH_HASH) begin
          if (hash_r < MAX_LEVEL) begin
            hash_nxt = hash_r + 1'b1;
            emit     = in_last;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end else if (in_byte == CH_SPACE) begin
          text_nxt    = pos_inc;
          content_nxt = pos_inc;
          if (in_last) begin
            emit = 1'b1;
          end else begin
            phase_nxt = PH_TEXT;
          end
        end else if (in_byte == CH_NL) begin
          // Hashes closed by a newline: empty text at the newline.
          emit     = 1'b1;
          tb       = pos_r;
          ts       = pos_r;
          line_end = 1'b1;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_TEXT: begin
        tb = text_r;
        if (in_byte == CH_NL) begin
          emit     = 1'b1;
          ts       = content_r;
          line_end = 1'b1;
        end else begin
          // Trailing spaces and hashes do not extend the text.
          if (in_byte != CH_SPACE && in_byte != CH_HASH) begin
            content_nxt = pos_inc;
          end
          ts   = content_nxt;
          emit = in_last;
        end
      end
      PH_SKIP: begin
        line_end = (in_byte == CH_NL);
      end
      default: begin
        phase_nxt = PH_LINE;
      end
    endcase

    // The final byte closes the document and starts over at position zero.
    if (in_last) begin
      phase_nxt   = PH_LINE;
      hash_nxt    = '0;
      start_nxt   = '0;
      text_nxt    = '0;
      content_nxt = '0;
      pos_nxt     = '0;
    end else if (line_end) begin
      phase_nxt = PH_LINE;
    end
  end

  // Report fields, fitted to the result width.
  always_comb begin
    result.level         = hash_nxt;
    result.heading_start = OUT_POS_W'(start_nxt);
    result.text_begin    = OUT_POS_W'(tb);
    result.text_stop     = OUT_POS_W'(ts);
    result.heading_stop  = OUT_POS_W'(hs);
    if (in_last) begin
      result.level         = (phase_r == PH_LINE) ? 3'd1 : hash_r + 3'(phase_r == PH_HASH
                             && in_byte == CH_HASH);
      result.heading_start = (phase_r == PH_LINE) ? OUT_POS_W'(pos_r) : OUT_POS_W'(start_r);
    end
  end

  // Scanner state, advanced on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LINE;
      hash_r    <= '0;
      pos_r     <= '0;
      start_r   <= '0;
      text_r    <= '0;
      content_r <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hash_r    <= hash_nxt;
      pos_r     <= pos_nxt;
      start_r   <= start_nxt;
      text_r    <= text_nxt;
      content_r <= content_nxt;
    end
  end

endmodule
